FILE: rtl/c16f_pkg.sv
// ----------------------------------------------------------------------------
// c16f_pkg - shared types and functions of the CRC-16 packet framer
// Holds the input transaction layout, frame constants and the CRC byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package c16f_pkg;

   localparam int unsigned IDX_W = 4;    // byte position within one item's burst

   localparam logic [7:0]  MARK_A      = 8'hA5;
   localparam logic [7:0]  MARK_B      = 8'h5A;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [7:0]  MEAS_LENGTH = 8'd4;

   // action codes
   localparam logic [1:0] ACT_BEGIN   = 2'd0;
   localparam logic [1:0] ACT_PAYLOAD = 2'd1;
   localparam logic [1:0] ACT_MEAS    = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_ORDER  = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic [7:0]         packet_type;
      logic [7:0]         payload_length;
      logic [7:0]         data_byte;
      logic signed [16:0] bearing_hundredths;
      logic signed [17:0] strength_value;
   } item_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_end;
      logic [1:0] status;
   } result_type;

   // CRC-16/CCITT-FALSE, one byte, msb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/crc16_packet_framer.sv
// ----------------------------------------------------------------------------
// crc16_packet_framer - serial frame builder with CRC-16/CCITT-FALSE
// Turns begin, payload and measurement transactions into frame bytes.
// ----------------------------------------------------------------------------
// A frame is A5, 5A, type, length, sequence, payload, then the CRC
// (CRC-16/CCITT-FALSE over type through payload) low byte first. A begin
// transaction yields the five header bytes (seven with the CRC when its length
// is zero), a payload transaction yields its byte (three with the CRC on the
// last one), a measurement yields a whole 11-byte frame, and a rejected or
// out-of-order transaction yields one byte with tlast set and a status code.
// The result port moves one byte per cycle while rsp_tready is high, and a
// transaction has from 1 to 11 result bytes; the sequencer emits one byte a
// cycle and updates the CRC by one byte a cycle whenever it is not stalled.
// Payload bytes stream one in, one out at full rate when not stalled. A new
// transaction is taken in the cycle the previous one moves its last byte into
// the result register. In any cycle where the result register holds a byte and
// rsp_tready is low, the sequencer stalls and holds req_tready low while it
// holds a transaction. Write the configuration registers only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_packet_framer
   import c16f_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] packet_type, [15:8] payload_length, [23:16] data_byte,
   // [40:24] bearing_hundredths, [58:41] strength_value, [63:59] zero
   input  wire logic [63:0] req_tdata,
   // [1:0] action
   input  wire logic [1:0]  req_tuser,
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] tx_byte
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,      // frame_end
   // [1:0] status
   output logic [1:0]       rsp_tuser,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);

   localparam logic CSR_DEBUG_MODE = 1'b0;
   localparam logic CSR_MEAS_TYPE  = 1'b1;

   logic       debug_mode_ff;
   logic [7:0] meas_type_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   item_type   req_item;
   logic       seq_out_ready, seq_out_valid;
   result_type seq_result;

   // unpack the request transaction
   assign req_item = '{
      action:             req_tuser,
      packet_type:        req_tdata[7:0],
      payload_length:     req_tdata[15:8],
      data_byte:          req_tdata[23:16],
      bearing_hundredths: req_tdata[40:24],
      strength_value:     req_tdata[58:41]
   };

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debug_mode_ff <= 1'b0;
         meas_type_ff  <= 8'd1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEBUG_MODE: debug_mode_ff <= csr_wdata[0];
            CSR_MEAS_TYPE:  meas_type_ff  <= csr_wdata;
            default:        debug_mode_ff <= debug_mode_ff;
         endcase
      end
   end

   // advance the sequencer whenever the result register is free or draining
   assign seq_out_ready = !rsp_valid_ff || rsp_tready;

   c16f_seq #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (req_tvalid),
      .item_ready       (req_tready),
      .item             (req_item),
      .debug_mode       (debug_mode_ff),
      .measurement_type (meas_type_ff),
      .out_ready        (seq_out_ready),
      .out_valid        (seq_out_valid),
      .out_result       (seq_result)
   );

   // result register: load on a new byte, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (seq_out_ready) begin
         rsp_valid_in = seq_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_out_valid) begin
         rsp_ff <= seq_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.tx_byte;
   assign rsp_tlast  = rsp_ff.frame_end;
   assign rsp_tuser  = rsp_ff.status;

endmodule

`default_nettype wire

FILE: rtl/c16f_seq.sv
// ----------------------------------------------------------------------------
// c16f_seq - frame byte sequencer
// Holds the current transaction and emits its result bytes one per cycle while
// out_ready is high; keeps sequence number, running CRC, open-packet state.
// ----------------------------------------------------------------------------
`default_nettype none

module c16f_seq
   import c16f_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_valid,
   output logic            item_ready,
   input  wire item_type   item,
   input  wire logic       debug_mode,
   input  wire logic [7:0] measurement_type,
   input  wire logic       out_ready,
   output logic            out_valid,
   output result_type      out_result
);

   localparam logic [2:0] K_ORDER    = 3'd0;
   localparam logic [2:0] K_REJECT   = 3'd1;
   localparam logic [2:0] K_BEGIN    = 3'd2;
   localparam logic [2:0] K_BEGIN0   = 3'd3;
   localparam logic [2:0] K_PAY      = 3'd4;
   localparam logic [2:0] K_PAY_LAST = 3'd5;
   localparam logic [2:0] K_MEAS     = 3'd6;

   logic             cur_valid_ff, cur_valid_in;
   item_type         cur_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [2:0]       kind_ff;
   logic [7:0]       seq_ff, seq_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       remain_ff, remain_in;
   logic             open_ff, open_in;

   logic       fire, load, last, covered, trail_hi, open_set;
   logic [2:0] kind_new, kind;
   logic [7:0] tx_byte;
   logic       frame_end;
   logic [1:0] status;
   logic [15:0] bw, sw;

   // clamp the measurement values
   always_comb begin
      if (cur_ff.bearing_hundredths < -17'sd18000) begin
         bw = 16'(-17'sd18000);
      end else if (cur_ff.bearing_hundredths > 17'sd18000) begin
         bw = 16'd18000;
      end else begin
         bw = cur_ff.bearing_hundredths[15:0];
      end
      if (cur_ff.strength_value[17]) begin
         sw = 16'd0;
      end else if (cur_ff.strength_value[16]) begin
         sw = 16'hFFFF;
      end else begin
         sw = cur_ff.strength_value[15:0];
      end
   end

   // classify at the first byte; later bytes follow the latched kind
   always_comb begin
      unique case (cur_ff.action)
         ACT_BEGIN: begin
            if (open_ff) begin
               kind_new = K_ORDER;
            end else if (debug_mode || (cur_ff.payload_length > 8'(MAX_PAYLOAD))) begin
               kind_new = K_REJECT;
            end else if (cur_ff.payload_length == 8'd0) begin
               kind_new = K_BEGIN0;
            end else begin
               kind_new = K_BEGIN;
            end
         end
         ACT_PAYLOAD: begin
            if (!open_ff) begin
               kind_new = K_ORDER;
            end else if (remain_ff == 8'd1) begin
               kind_new = K_PAY_LAST;
            end else begin
               kind_new = K_PAY;
            end
         end
         ACT_MEAS: begin
            if (open_ff) begin
               kind_new = K_ORDER;
            end else if (debug_mode) begin
               kind_new = K_REJECT;
            end else begin
               kind_new = K_MEAS;
            end
         end
         default: kind_new = K_ORDER;
      endcase
      kind = (idx_ff == '0) ? kind_new : kind_ff;
   end

   // byte select
   always_comb begin
      tx_byte   = 8'h00;
      frame_end = 1'b0;
      status    = ST_OK;
      covered   = 1'b0;
      trail_hi  = 1'b0;
      open_set  = 1'b0;
      last      = 1'b0;
      unique case (kind) inside
         K_ORDER, K_REJECT: begin
            frame_end = 1'b1;
            status    = (kind == K_ORDER) ? ST_ORDER : ST_REJECT;
            last      = 1'b1;
         end
         K_PAY, K_PAY_LAST: begin
            unique case (idx_ff)
               4'd0: begin
                  tx_byte = cur_ff.data_byte;
                  covered = 1'b1;
                  last    = (kind == K_PAY);
               end
               4'd1: tx_byte = crc_ff[7:0];
               default: begin
                  tx_byte   = crc_ff[15:8];
                  frame_end = 1'b1;
                  trail_hi  = 1'b1;
                  last      = 1'b1;
               end
            endcase
         end
         default: begin
            unique case (idx_ff)
               4'd0: tx_byte = MARK_A;
               4'd1: tx_byte = MARK_B;
               4'd2: begin
                  tx_byte = (kind == K_MEAS) ? measurement_type : cur_ff.packet_type;
                  covered = 1'b1;
               end
               4'd3: begin
                  tx_byte = (kind == K_MEAS) ? MEAS_LENGTH : cur_ff.payload_length;
                  covered = 1'b1;
               end
               4'd4: begin
                  tx_byte  = seq_ff;
                  covered  = 1'b1;
                  open_set = (kind == K_BEGIN);
                  last     = (kind == K_BEGIN);
               end
               4'd5: begin
                  tx_byte = (kind == K_MEAS) ? bw[7:0] : crc_ff[7:0];
                  covered = (kind == K_MEAS);
               end
               4'd6: begin
                  if (kind == K_MEAS) begin
                     tx_byte = bw[15:8];
                     covered = 1'b1;
                  end else begin
                     tx_byte   = crc_ff[15:8];
                     frame_end = 1'b1;
                     trail_hi  = 1'b1;
                     last      = 1'b1;
                  end
               end
               4'd7: begin
                  tx_byte = sw[7:0];
                  covered = 1'b1;
               end
               4'd8: begin
                  tx_byte = sw[15:8];
                  covered = 1'b1;
               end
               4'd9: tx_byte = crc_ff[7:0];
               default: begin
                  tx_byte   = crc_ff[15:8];
                  frame_end = 1'b1;
                  trail_hi  = 1'b1;
                  last      = 1'b1;
               end
            endcase
         end
      endcase
   end

   assign fire       = cur_valid_ff && out_ready;
   assign item_ready = !cur_valid_ff || (fire && last);
   assign load       = item_valid && item_ready;
   assign out_valid  = fire;
   assign out_result = '{tx_byte: tx_byte, frame_end: frame_end, status: status};

   // next state of the frame
   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      seq_in       = seq_ff;
      crc_in       = crc_ff;
      remain_in    = remain_ff;
      open_in      = open_ff;
      if (fire) begin
         idx_in = last ? '0 : idx_ff + 1'b1;
         if (last) begin
            cur_valid_in = 1'b0;
         end
         if (idx_ff == '0 && (kind == K_BEGIN || kind == K_BEGIN0 || kind == K_MEAS)) begin
            crc_in = CRC_INIT;
         end
         if (covered) begin
            crc_in = crc_byte(crc_ff, tx_byte);
         end
         if (idx_ff == '0 && (kind == K_PAY || kind == K_PAY_LAST)) begin
            remain_in = remain_ff - 8'd1;
         end
         if (open_set) begin
            open_in   = 1'b1;
            remain_in = cur_ff.payload_length;
         end
         if (trail_hi) begin
            seq_in    = seq_ff + 8'd1;
            crc_in    = CRC_INIT;
            remain_in = 8'd0;
            open_in   = 1'b0;
         end
      end
      if (load) begin
         cur_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         seq_ff       <= 8'd0;
         crc_ff       <= CRC_INIT;
         remain_ff    <= 8'd0;
         open_ff      <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         seq_ff       <= seq_in;
         crc_ff       <= crc_in;
         remain_ff    <= remain_in;
         open_ff      <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= item;
      end
      if (fire && idx_ff == '0) begin
         kind_ff <= kind;
      end
   end

endmodule

`default_nettype wire

FILE: dv/crc16_packet_framer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc16_packet_framer_tb - self-checking bench for the CRC-16 frame builder
// Drives begin, payload, measurement and illegal request transactions, rebuilds
// every frame byte, CRC and status code in a local predictor and compares the
// response stream byte by byte under random stalls on both sides.
// ----------------------------------------------------------------------------
module crc16_packet_framer_tb;
   import c16f_pkg::*;

   localparam int MAX_PAYLOAD      = 64;
   localparam int BEARING_LIMIT    = 18000;   // hundredths of a degree
   localparam int STRENGTH_CEILING = 65535;
   localparam int BURST_CYCLES     = 12;      // longest burst is 11 bytes, plus the output register
   localparam int LIMIT_CYCLES     = 400000;
   localparam int ITEM_TARGET      = 480;
   localparam int SEGMENTS         = 6;
   localparam int PRINT_CAP        = 40;
   localparam int N_ROWS           = 29;

   localparam logic [1:0] ACT_ILLEGAL    = 2'd3;
   localparam logic       REG_DEBUG_MODE = 1'b0;
   localparam logic       REG_MEAS_TYPE  = 1'b1;

   typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_type;
   // how a directed row is checked: by the predictor, or by a typed-in error byte
   typedef enum logic [1:0] {CHK_MODEL, CHK_REJECT, CHK_ORDER} row_check_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [1:0]         action;
      logic [7:0]         ptype;
      logic [7:0]         plen;
      logic [7:0]         data;
      logic signed [16:0] brg;
      logic signed [17:0] str;
      row_check_type      check;
      logic               csr_sel;
      logic [7:0]         csr_val;
   } stim_row_type;

   // ------------------------------------------------------------------------
   // DUT signals
   // ------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;
   logic        csr_wr_en;
   logic        csr_index;
   logic [7:0]  csr_wdata;

   crc16_packet_framer #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor state: its own copy of the registers and the framer state
   // ------------------------------------------------------------------------
   logic        cfg_debug;
   logic [7:0]  cfg_meas_type;
   logic [7:0]  seq_number;
   logic [15:0] frame_crc;
   logic [7:0]  payload_left;
   logic        frame_open;

   result_type  frame_burst[$];          // bytes caused by the transaction just taken
   result_type  pending_frame_bytes[$];  // bytes still owed by the DUT, oldest first

   int send_idle_pct;
   int rsp_stall_pct;
   int items_accepted;
   int bytes_checked;
   int frames_done;
   int rejects_seen;
   int order_seen;
   int csr_writes;
   int mismatch_count;
   int cycle_count;

   // Directed stimulus. Error rows carry their expected byte inline; the rest go
   // through the predictor.
   stim_row_type directed_rows [N_ROWS] = '{
      // payload and illegal action with nothing open
      '{ROW_ITEM,  ACT_PAYLOAD, 8'h00, 8'h00, 8'hFF, 17'sd0, 18'sd0, CHK_ORDER,
        REG_DEBUG_MODE, 8'h00},
      '{ROW_ITEM,  ACT_ILLEGAL, 8'hFF, 8'hFF, 8'hFF, 17'sd65535, 18'sd131071, CHK_ORDER,
        REG_DEBUG_MODE, 8'h00},
      // oversize lengths: just past the limit and the top of the field
      '{ROW_ITEM,  ACT_BEGIN,   8'h12, 8'd65,  8'h00, 17'sd0, 18'sd0, CHK_REJECT,
        REG_DEBUG_MODE, 8'h00},
      '{ROW_ITEM,  ACT_BEGIN,   8'hFF, 8'hFF, 8'h00, 17'sd0, 18'sd0, CHK_REJECT,
        REG_DEBUG_MODE, 8'h00},
      // zero length frame closes inside the begin
      '{ROW_ITEM,  ACT_BEGIN,   8'h00, 8'h00, 8'h00, 17'sd0, 18'sd0, CHK_MODEL,
        REG_DEBUG_MODE, 8'h00},
      '{ROW_ITEM,  ACT_BEGIN,   8'hFF, 8'h01, 8'h00, 17'sd0, 18'sd0, CHK_MODEL,
        REG_DEBUG_MODE, 8'h00},
      '{ROW_ITEM,  ACT_PAYLOAD, 8'h00, 8'h00, 8'h00, 17'sd0, 18'sd0, CHK_MODEL,
        REG_DEBUG_MODE, 8'h00},
      // begin and measurement while a frame is open
      '{ROW_ITEM,  ACT_BEGIN,   8'h3C, 8'h02, 8'h00, 17'sd0, 18'sd0, CHK_MODEL,
        REG_DEBUG_MODE, 8'h00},
      '{ROW_ITEM,  ACT_BEGIN,   8'h3C, 8'h01, 8'h00, 17'sd0, 18'sd0, CHK_ORDER,
        REG_DEBUG_MODE, 8'h00},
      '{ROW_ITEM,  ACT_MEAS,    8'h00, 8'h00, 8'h00, 17'sd0, 18'sd0, CHK_ORDER,
        REG_DEBUG_MODE, 8'h00},
      '{ROW_ITEM,  ACT_PAYLOAD, 8'h00, 8'h00, 8'hAA, 17'sd0, 18'sd0, CHK_MODEL,
        REG_DEBUG_MODE, 8'h00},
      '{ROW_ITEM,  ACT_PAYLOAD, 8'h00, 8'h00, 8'h55, 17'sd0, 18'sd0, CHK_MODEL,
        REG_DEBUG_MODE, 8'h00},
      // measurement clamping: field extremes, one past each clamp, the clamps
      '{ROW_ITEM,  ACT_MEAS,    8'h00, 8'h00, 8'h00, 17'sh10000, 18'sh20000, CHK_MODEL,
        REG_DEBUG_MODE, 8'h00},
      '{ROW_ITEM,  ACT_MEAS,    8'h00, 8'h00, 8'h00, 17'sd65535, 18'sd131071, CHK_MODEL,
        REG_DEBUG_MODE, 8'h00},
      '{ROW_ITEM,  ACT_MEAS,    8'h00, 8'h00, 8'h00, -17'sd18001, 18'sd65536, CHK_MODEL,
        REG_DEBUG_MODE, 8'h00},
      '{ROW_ITEM,  ACT_MEAS,    8'h00, 8'h00, 8'h00, 17'sd18001, -18'sd1, CHK_MODEL,
        REG_DEBUG_MODE, 8'h00},
      '{ROW_ITEM,  ACT_MEAS,    8'h00, 8'h00, 8'h00, -17'sd18000, 18'sd65535, CHK_MODEL,
        REG_DEBUG_MODE, 8'h00},
      '{ROW_ITEM,  ACT_MEAS,    8'h00, 8'h00, 8'h00, 17'sd18000, 18'sd0, CHK_MODEL,
        REG_DEBUG_MODE, 8'h00},
      // measurement type: one frame with FF, then the register written to 00
      '{ROW_WRITE, ACT_BEGIN,   8'h00, 8'h00, 8'h00, 17'sd0, 18'sd0, CHK_MODEL,
        REG_MEAS_TYPE, 8'hFF},
      '{ROW_ITEM,  ACT_MEAS,    8'h00, 8'h00, 8'h00, 17'sd0, 18'sd1, CHK_MODEL,
        REG_DEBUG_MODE, 8'h00},
      '{ROW_WRITE, ACT_BEGIN,   8'h00, 8'h00, 8'h00, 17'sd0, 18'sd0, CHK_MODEL,
        REG_MEAS_TYPE, 8'h00},
      // debug mode raised mid-frame: the open frame still completes
      '{ROW_ITEM,  ACT_BEGIN,   8'h81, 8'h01, 8'h00, 17'sd0, 18'sd0, CHK_MODEL,
        REG_DEBUG_MODE, 8'h00},
      '{ROW_WRITE, ACT_BEGIN,   8'h00, 8'h00, 8'h00, 17'sd0, 18'sd0, CHK_MODEL,
        REG_DEBUG_MODE, 8'h01},
      '{ROW_ITEM,  ACT_PAYLOAD, 8'h00, 8'h00, 8'h7E, 17'sd0, 18'sd0, CHK_MODEL,
        REG_DEBUG_MODE, 8'h00},
      '{ROW_ITEM,  ACT_BEGIN,   8'h00, 8'h00, 8'h00, 17'sd0, 18'sd0, CHK_REJECT,
        REG_DEBUG_MODE, 8'h00},
      '{ROW_ITEM,  ACT_MEAS,    8'h00, 8'h00, 8'h00, 17'sd0, 18'sd0, CHK_REJECT,
        REG_DEBUG_MODE, 8'h00},
      '{ROW_ITEM,  ACT_PAYLOAD, 8'h00, 8'h00, 8'h00, 17'sd0, 18'sd0, CHK_ORDER,
        REG_DEBUG_MODE, 8'h00},
      '{ROW_WRITE, ACT_BEGIN,   8'h00, 8'h00, 8'h00, 17'sd0, 18'sd0, CHK_MODEL,
        REG_DEBUG_MODE, 8'h00},
      '{ROW_WRITE, ACT_BEGIN,   8'h00, 8'h00, 8'h00, 17'sd0, 18'sd0, CHK_MODEL,
        REG_MEAS_TYPE, 8'h01}
   };

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic void put_byte(input logic [7:0] b, input logic last,
                                    input logic [1:0] st);
      result_type r;
      r.tx_byte   = b;
      r.frame_end = last;
      r.status    = st;
      frame_burst.push_back(r);
      if (st == ST_REJECT) rejects_seen++;
      if (st == ST_ORDER) order_seen++;
   endfunction

   // Fold one byte into the running CRC, bit serial, msb first
   function automatic void put_covered(input logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb        = frame_crc[15] ^ b[i];
         frame_crc = {frame_crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      put_byte(b, 1'b0, ST_OK);
   endfunction

   function automatic void put_header(input logic [7:0] ptype, input logic [7:0] plen);
      frame_crc = CRC_INIT;
      put_byte(MARK_A, 1'b0, ST_OK);
      put_byte(MARK_B, 1'b0, ST_OK);
      put_covered(ptype);
      put_covered(plen);
      put_covered(seq_number);
   endfunction

   // CRC low byte first, then close the frame and advance the sequence
   function automatic void put_trailer();
      put_byte(frame_crc[7:0], 1'b0, ST_OK);
      put_byte(frame_crc[15:8], 1'b1, ST_OK);
      seq_number   = seq_number + 8'd1;
      frame_crc    = CRC_INIT;
      payload_left = 8'd0;
      frame_open   = 1'b0;
      frames_done++;
   endfunction

   function automatic void frame_bytes_for(input item_type it);
      int          brg;
      int          str;
      logic [31:0] bw;
      logic [31:0] sw;
      frame_burst = {};
      case (it.action)
         ACT_BEGIN: begin
            if (frame_open) begin
               put_byte(8'h00, 1'b1, ST_ORDER);
            end else if (cfg_debug || int'(it.payload_length) > MAX_PAYLOAD) begin
               put_byte(8'h00, 1'b1, ST_REJECT);
            end else begin
               put_header(it.packet_type, it.payload_length);
               if (it.payload_length == 8'd0) begin
                  put_trailer();
               end else begin
                  frame_open   = 1'b1;
                  payload_left = it.payload_length;
               end
            end
         end
         ACT_PAYLOAD: begin
            if (!frame_open) begin
               put_byte(8'h00, 1'b1, ST_ORDER);
            end else begin
               put_covered(it.data_byte);
               payload_left = payload_left - 8'd1;
               if (payload_left == 8'd0) put_trailer();
            end
         end
         ACT_MEAS: begin
            if (frame_open) begin
               put_byte(8'h00, 1'b1, ST_ORDER);
            end else if (cfg_debug) begin
               put_byte(8'h00, 1'b1, ST_REJECT);
            end else begin
               brg = $signed(it.bearing_hundredths);
               str = $signed(it.strength_value);
               if (brg < -BEARING_LIMIT) brg = -BEARING_LIMIT;
               if (brg > BEARING_LIMIT) brg = BEARING_LIMIT;
               if (str < 0) str = 0;
               if (str > STRENGTH_CEILING) str = STRENGTH_CEILING;
               bw = brg;
               sw = str;
               put_header(cfg_meas_type, MEAS_LENGTH);
               put_covered(bw[7:0]);
               put_covered(bw[15:8]);
               put_covered(sw[7:0]);
               put_covered(sw[15:8]);
               put_trailer();
            end
         end
         default: begin
            put_byte(8'h00, 1'b1, ST_ORDER);
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Present one transaction, hold it until the handshake, then log what it owes.
   // Leave req_tvalid high on return so a back-to-back transaction needs no toggle.
   task automatic send_item(input item_type it, input row_check_type check);
      result_type typed;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.action;
      req_tdata  <= {5'b0, it.strength_value, it.bearing_hundredths, it.data_byte,
                     it.payload_length, it.packet_type};
      do @(posedge clock); while (!req_tready);
      items_accepted++;
      frame_bytes_for(it);
      if (check == CHK_MODEL) begin
         foreach (frame_burst[i]) pending_frame_bytes.push_back(frame_burst[i]);
      end else begin
         typed.tx_byte   = 8'h00;
         typed.frame_end = 1'b1;
         typed.status    = (check == CHK_REJECT) ? ST_REJECT : ST_ORDER;
         pending_frame_bytes.push_back(typed);
      end
   endtask

   // Stop sending, wait out every owed byte, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_frame_bytes.size() != 0) @(posedge clock);
      repeat (BURST_CYCLES) @(posedge clock);
   endtask

   // Registers change only with the block idle
   task automatic write_reg(input logic sel, input logic [7:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (sel == REG_DEBUG_MODE) cfg_debug = value[0];
      else cfg_meas_type = value;
      csr_writes++;
   endtask

   function automatic item_type rand_item(input logic [1:0] action);
      item_type it;
      it.action             = action;
      it.packet_type        = 8'($urandom);
      it.payload_length     = 8'($urandom);
      it.data_byte          = 8'($urandom);
      it.bearing_hundredths = 17'($urandom);
      it.strength_value     = 18'($urandom);
      return it;
   endfunction

   // Mostly short frames, some full-size ones, a few empty ones
   function automatic logic [7:0] pick_length();
      case ($urandom_range(9))
         0: return 8'(MAX_PAYLOAD);
         1: return 8'($urandom_range(MAX_PAYLOAD));
         default: return 8'($urandom_range(8));
      endcase
   endfunction

   // One unit of random traffic; every unit leaves no frame open
   task automatic send_random_unit();
      item_type    it;
      int          sel;
      int          len;
      int          cut;
      sel = $urandom_range(99);
      if (sel < 40) begin
         // well-formed frame with random content
         it = rand_item(ACT_BEGIN);
         it.payload_length = pick_length();
         len = it.payload_length;
         send_item(it, CHK_MODEL);
         repeat (len) send_item(rand_item(ACT_PAYLOAD), CHK_MODEL);
      end else if (sel < 72) begin
         it = rand_item(ACT_MEAS);
         case ($urandom_range(3))
            0: ;  // full-range raw values, mostly clamped
            1: it.bearing_hundredths = 17'(($urandom_range(1) ? BEARING_LIMIT : -BEARING_LIMIT)
                                           + int'($urandom_range(4)) - 2);
            2: begin
               it.bearing_hundredths = 17'(int'($urandom_range(2 * BEARING_LIMIT))
                                           - BEARING_LIMIT);
               it.strength_value     = 18'($urandom_range(STRENGTH_CEILING));
            end
            default: it.strength_value = 18'(($urandom_range(1) ? STRENGTH_CEILING + 1 : 0)
                                             - int'($urandom_range(1)));
         endcase
         send_item(it, CHK_MODEL);
      end else if (sel < 86) begin
         // single stray transaction
         case ($urandom_range(2))
            0: it = rand_item(ACT_PAYLOAD);
            1: it = rand_item(ACT_ILLEGAL);
            default: begin
               it = rand_item(ACT_BEGIN);
               it.payload_length = 8'($urandom_range(255, MAX_PAYLOAD + 1));
            end
         endcase
         send_item(it, CHK_MODEL);
      end else begin
         // frame broken by an intruder, then finished
         it = rand_item(ACT_BEGIN);
         len = $urandom_range(6, 2);
         it.payload_length = 8'(len);
         cut = $urandom_range(len - 1);
         send_item(it, CHK_MODEL);
         repeat (cut) send_item(rand_item(ACT_PAYLOAD), CHK_MODEL);
         case ($urandom_range(2))
            0: send_item(rand_item(ACT_BEGIN), CHK_MODEL);
            1: send_item(rand_item(ACT_MEAS), CHK_MODEL);
            default: send_item(rand_item(ACT_ILLEGAL), CHK_MODEL);
         endcase
         repeat (len - cut) send_item(rand_item(ACT_PAYLOAD), CHK_MODEL);
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h (byte %0d)",
                  $time, what, got, want, bytes_checked);
   endtask

   // Compare each accepted byte against the oldest owed one
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_frame_bytes.size() == 0) begin
            report_mismatch("response with nothing owed, tdata", rsp_tdata, 0);
         end else begin
            want = pending_frame_bytes.pop_front();
            if (rsp_tdata !== want.tx_byte)
               report_mismatch("tx_byte", rsp_tdata, want.tx_byte);
            if (rsp_tlast !== want.frame_end)
               report_mismatch("frame_end", rsp_tlast, want.frame_end);
            if (rsp_tuser !== want.status)
               report_mismatch("status", rsp_tuser, want.status);
         end
         bytes_checked++;
      end
   end

   // Hard stop if the handshake hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timed out after %0d cycles, %0d bytes still owed",
                  cycle_count, pending_frame_bytes.size());
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      item_type it;
      int       base;
      int       stop_at;
      // known values on every input from time zero
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ACT_BEGIN;
      rsp_tready = 1'b0;
      csr_wr_en  = 1'b0;
      csr_index  = REG_DEBUG_MODE;
      csr_wdata  = 8'h00;
      // predictor reset state
      cfg_debug     = 1'b0;
      cfg_meas_type = 8'h01;
      seq_number    = 8'h00;
      frame_crc     = CRC_INIT;
      payload_left  = 8'h00;
      frame_open    = 1'b0;
      send_idle_pct = 36;
      rsp_stall_pct = 69;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            write_reg(directed_rows[i].csr_sel, directed_rows[i].csr_val);
         end else begin
            it.action             = directed_rows[i].action;
            it.packet_type        = directed_rows[i].ptype;
            it.payload_length     = directed_rows[i].plen;
            it.data_byte          = directed_rows[i].data;
            it.bearing_hundredths = directed_rows[i].brg;
            it.strength_value     = directed_rows[i].str;
            send_item(it, directed_rows[i].check);
         end
      end

      // random traffic in segments; each segment boundary drains the block
      // completely before the registers move
      base = items_accepted;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg < 2) begin
            send_idle_pct = 36;
            rsp_stall_pct = 69;
         end else if (seg < 4) begin
            send_idle_pct = 69;
            rsp_stall_pct = 36;
         end else begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         write_reg(REG_MEAS_TYPE, 8'($urandom));
         if (seg == 3) begin
            // short stretch with every begin and measurement refused
            write_reg(REG_DEBUG_MODE, 8'h01);
            stop_at = items_accepted + 16;
            while (items_accepted < stop_at) send_random_unit();
            write_reg(REG_DEBUG_MODE, 8'h00);
         end
         while (items_accepted < base + (seg + 1) * (ITEM_TARGET - base) / SEGMENTS)
            send_random_unit();
      end

      drain();

      $display("Covered %0d request transactions and %0d response bytes: %0d frames built,",
               items_accepted, bytes_checked, frames_done);
      $display("%0d refused, %0d out of order, %0d register writes, three idle mixes.",
               rejects_seen, order_seen, csr_writes);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/c16f_pkg.sv
rtl/c16f_seq.sv
rtl/crc16_packet_framer.sv
dv/crc16_packet_framer_tb.sv
